### sv/modular_exponentiation_key_agreement_unit_defines.svh
// Assertion macros for the checker file of the modular exponentiation unit.
// No dependencies; include by bare file name.
`ifndef MODULAR_EXPONENTIATION_KEY_AGREEMENT_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_KEY_AGREEMENT_UNIT_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define MEXP_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define MEXP_ASSERT(lbl, prop, msg) \
	`MEXP_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### sv/mexp_pkg.sv
// Package for the modular exponentiation unit: field widths, reset values,
// register indexes and the sequencer state type. No dependencies.
package mexp_pkg;

	localparam int FIELD_W           = 32;
	localparam int ADDR_W            = 3;
	localparam int OPERAND_BITS_DEF  = 32;
	localparam int EXPONENT_BITS_DEF = 32;

	localparam logic [FIELD_W-1:0] MODULUS_RESET   = 32'd2147483647;
	localparam logic [FIELD_W-1:0] GENERATOR_RESET = 32'd5;

	// register index, taken from paddr[2]
	localparam logic REG_MODULUS   = 1'b0;
	localparam logic REG_GENERATOR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

endpackage

### sv/modular_exponentiation_key_agreement_unit.sv
// Sequencing: when modulus or exponent is zero the request goes straight to the done
//   state; else the base is reduced, then the exponent is walked with multiplies and squares.
// Throughput: one request at a time; the bit-serial modular multiplier (one multiplier
//   bit per cycle) sets it.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending, modulus and
//   generator back to 2147483647 and 5.
module modular_exponentiation_key_agreement_unit
	import mexp_pkg::*;
#(
	parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
	parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [FIELD_W-1:0] pwdata,
	output logic [FIELD_W-1:0] prdata,
	output logic               pready,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [FIELD_W-1:0] exponent,
	input  logic [FIELD_W-1:0] peer_public,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FIELD_W-1:0] power_result
);

	localparam int N     = OPERAND_BITS;
	// exponent bits above the field width are always zero
	localparam int EW    = (EXPONENT_BITS < FIELD_W) ? EXPONENT_BITS : FIELD_W;
	localparam int CNT_W = $clog2(N);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

	mexp_state_t      state_q, state_d;
	logic [N-1:0]     mod_q, gen_q;
	logic [N-1:0]     acc_q, base_q, r_q, a_q, res_q;
	logic [EW-1:0]    exp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic             cfg_wr;
	logic             accept_in;
	logic             out_free;
	logic             out_load;
	logic             stepping;
	logic             op_last;
	logic             a_bit;
	logic [N-1:0]     addend;
	logic [N+1:0]     t_sum, m1, m2, step_w;
	logic [N-1:0]     step_r;
	logic [N-1:0]     base_sel;
	logic [EW-1:0]    exp_in;

	// ---------------------------------------------------------------
	// Configuration registers. paddr[1:0] is the byte offset inside a
	// word and takes no part in decoding; pready is always high.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET[N-1:0];
			gen_q <= GENERATOR_RESET[N-1:0];
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODULUS:   mod_q <= pwdata[N-1:0];
				REG_GENERATOR: gen_q <= pwdata[N-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODULUS:   prdata = FIELD_W'(mod_q);
			REG_GENERATOR: prdata = FIELD_W'(gen_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Bit-serial modular multiplier: r = (2r + addend) mod m, one bit of
	// the multiplier (a_q, MSB first) per cycle. With r < m and the addend
	// below m, the sum stays below 3m, so one of t, t-m, t-2m is the
	// result. During base reduction the addend is the raw base bit itself.
	// ---------------------------------------------------------------
	assign a_bit  = a_q[N-1];
	assign addend = (state_q == ST_REDUCE) ? N'(a_bit) : (a_bit ? base_q : '0);
	assign t_sum  = {1'b0, r_q, 1'b0} + {2'b00, addend};
	assign m1     = {2'b00, mod_q};
	assign m2     = {1'b0, mod_q, 1'b0};

	always_comb begin
		if (t_sum >= m2) begin
			step_w = t_sum - m2;
		end else if (t_sum >= m1) begin
			step_w = t_sum - m1;
		end else begin
			step_w = t_sum;
		end
	end

	assign step_r  = step_w[N-1:0];
	assign op_last = (cnt_q == CNT_LAST);

	// ---------------------------------------------------------------
	// Request decode: pick the base and keep the usable exponent bits.
	// ---------------------------------------------------------------
	assign base_sel  = cmd ? peer_public[N-1:0] : gen_q;
	assign exp_in    = exponent[EW-1:0];
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------
	// Sequencer: reduce the base, then walk the exponent LSB first,
	// multiplying on a set bit and squaring while higher bits remain.
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					// zero modulus or zero exponent: result is known at once
					if ((mod_q == '0) || (exp_in == '0)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (op_last) begin
					state_d = exp_q[0] ? ST_MUL : ST_SQR;
				end
			end
			ST_MUL: begin
				if (op_last) begin
					// skip the final square once no higher bit is left
					state_d = (exp_q[EW-1:1] == '0) ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR: begin
				if (op_last) begin
					state_d = exp_q[1] ? ST_MUL : ST_SQR;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		stepping = 1'b0;
		out_load = 1'b0;
		unique case (state_q) inside
			ST_IDLE:                    in_stall = 1'b0;
			ST_REDUCE, ST_MUL, ST_SQR:  stepping = 1'b1;
			ST_DONE:                    out_load = out_free;
			default:                    in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept_in || (stepping && op_last)) begin
				cnt_q <= '0;
			end else if (stepping) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers: shift the multiplier operand, accumulate the
	// partial remainder, and at the end of each pass load the next one.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					exp_q <= exp_in;
					a_q   <= base_sel;
					r_q   <= '0;
					acc_q <= (mod_q == '0) ? '0 : N'(1);
				end
			end
			ST_REDUCE: begin
				if (op_last) begin
					base_q <= step_r;
					r_q    <= '0;
					a_q    <= exp_q[0] ? acc_q : step_r;
				end else begin
					r_q <= step_r;
					a_q <= a_q << 1;
				end
			end
			ST_MUL: begin
				if (op_last) begin
					acc_q <= step_r;
					r_q   <= '0;
					a_q   <= base_q;
				end else begin
					r_q <= step_r;
					a_q <= a_q << 1;
				end
			end
			ST_SQR: begin
				if (op_last) begin
					base_q <= step_r;
					exp_q  <= exp_q >> 1;
					r_q    <= '0;
					a_q    <= exp_q[1] ? acc_q : step_r;
				end else begin
					r_q <= step_r;
					a_q <= a_q << 1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					res_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign power_result = FIELD_W'(res_q);

endmodule

### sv/mexp_checker.sv
// Port-level checker for the modular exponentiation unit, bound to the top level.
// Depends on mexp_pkg and modular_exponentiation_key_agreement_unit_defines.svh.
`include "modular_exponentiation_key_agreement_unit_defines.svh"

module mexp_checker
	import mexp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [FIELD_W-1:0] power_result
);

	// hold a stalled result
	`MEXP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(power_result), "stalled result changed")
	// go busy after taking a request
	`MEXP_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "request taken while busy")
	// a new result only ever follows a busy cycle
	`MEXP_ASSERT(a_result_after_busy, $rose(out_valid) |-> $past(in_stall), "result without request")

endmodule

bind modular_exponentiation_key_agreement_unit mexp_checker u_mexp_checker (.*);
